// ===== rtl/bnps_pkg.sv =====
`default_nettype none

package bnps_pkg;

    // datapath width for coordinates, curve points and distances
    localparam int CW = 40;
    // multiplier second operand: Q0.16 trig values, gain, parameter t
    localparam int MW = 18;
    // CORDIC angle accumulator, 2^-24 turn units plus headroom
    localparam int ZW = 25;
    localparam int CSTEPS = 16;
    // parameter t width, Q0.16 with room for 1.0
    localparam int TW = 17;

    localparam logic signed [MW-1:0] INV_GAIN = 18'sd39797;
    localparam logic [15:0] GAIN_RESET = 16'd54395;
    localparam logic [TW-1:0] ONE_Q16 = 17'd65536;

    // de Casteljau schedule on a four-entry shift line: a lerp op appends
    // lerp(q0,q1), a plain op only shifts. Bit i set means op i is a lerp.
    localparam int CUB_OPS = 9;
    localparam int OPW = $clog2(CUB_OPS);
    localparam logic [CUB_OPS-1:0] CUB_LERP = 9'b100110111;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic [15:0]        start_heading;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic [15:0]        end_heading;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic [TW-1:0]      search_low;
        logic [TW-1:0]      search_high;
        logic [3:0]         rounds;
    } query_t;

    typedef struct packed {
        logic [TW-1:0] result_low;
        logic [TW-1:0] result_high;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    function automatic logic signed [ZW-1:0] atan_step(input logic [3:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            4'd0:    v = 25'sd2097152;
            4'd1:    v = 25'sd1238021;
            4'd2:    v = 25'sd654136;
            4'd3:    v = 25'sd332050;
            4'd4:    v = 25'sd166669;
            4'd5:    v = 25'sd83416;
            4'd6:    v = 25'sd41718;
            4'd7:    v = 25'sd20860;
            4'd8:    v = 25'sd10430;
            4'd9:    v = 25'sd5215;
            4'd10:   v = 25'sd2608;
            4'd11:   v = 25'sd1304;
            4'd12:   v = 25'sd652;
            4'd13:   v = 25'sd326;
            4'd14:   v = 25'sd163;
            default: v = 25'sd81;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bnps_query_if.sv =====
`default_nettype none

interface bnps_query_if;
    logic              valid;
    logic              ready;
    bnps_pkg::query_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bnps_result_if.sv =====
`default_nettype none

interface bnps_result_if;
    logic               valid;
    logic               ready;
    bnps_pkg::result_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bnps_cfg_if.sv =====
`default_nettype none

interface bnps_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bezier_nearest_param_search.sv =====
`default_nettype none

// Nearest-parameter search on a cubic Bezier between two poses.
// query channel: one transaction carries start/end pose, target point, initial
//   parameter interval and round count. ready is high only while idle.
// result channel: one transaction per query with the final interval.
// cfg channel: write ctrl_gain (Q0.16); always ready, meant for idle periods.
// Sequence: setup is three CORDIC runs (start sin/cos, end sin/cos, chord
//   length) plus seven multiplier steps. Each round is a span/SAMPLES
//   reciprocal division plus SAMPLES+1 samples, each two de Casteljau
//   passes of 6 lerps and 3 shifts, then operand, launch and a CORDIC
//   magnitude; the round ends with the narrowing step.
// One query at a time: the multiplier and the CORDIC unit are shared by every
//   step under the sequencer below.
// Reset: rst_n asynchronous active low; sequencer idles, ctrl_gain returns to
//   54395. A stalled result holds valid and data; no new query is taken
//   until the result transaction completes.
module bezier_nearest_param_search #(
    parameter int SAMPLES    = 15,
    parameter int MAX_ROUNDS = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    bnps_query_if.sink         query,
    bnps_result_if.source      result,
    bnps_cfg_if.sink           cfg
);

    localparam int CW   = bnps_pkg::CW;
    localparam int MW   = bnps_pkg::MW;
    localparam int TW   = bnps_pkg::TW;
    localparam int RW   = $clog2(SAMPLES);
    localparam int KW   = $clog2(SAMPLES + 1);
    localparam int RNDW = $clog2(MAX_ROUNDS + 1);
    localparam int OPW  = bnps_pkg::OPW;

    typedef enum logic [4:0] {
        S_IDLE, S_SC_GO, S_SC_W, S_EC_GO, S_EC_W, S_CH_GO, S_CH_W,
        S_MUL_LEN, S_MUL_D, S_CTL0, S_CTL1, S_CTL2, S_CTL3, S_CTL4,
        S_ROUND, S_DIV_W, S_SAMP, S_CUB_SEL, S_CUB_MUL, S_CUB_ADD,
        S_DIST, S_DIST_GO, S_DIST_W, S_NARROW, S_OUT
    } state_t;

    // control
    state_t            state_reg;
    logic [15:0]       gain_reg;
    logic [RNDW-1:0]   rounds_left_reg;
    logic [KW-1:0]     k_reg;
    logic [OPW-1:0]    op_reg;
    logic              axis_reg;
    logic              pend_reg;

    // payload
    logic signed [31:0] sx_reg, sy_reg, ex_reg, ey_reg, tx_reg, ty_reg;
    logic [15:0]        sh_reg, eh_reg;
    logic [TW-1:0]      lo_reg, hi_reg;
    logic signed [MW-1:0] cs_reg, ss_reg, ce_reg, se_reg;
    logic signed [CW-1:0] d_reg, px1_reg, py1_reg, px2_reg, py2_reg;
    logic signed [CW-1:0] dx_reg, dy_reg;
    logic signed [CW-1:0] q0_reg, q1_reg, q2_reg, q3_reg, diff_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, best_reg;
    logic [TW-1:0]      t_reg, tprev_reg, nlo_reg, nhi_reg;
    logic [TW-1:0]      qs_reg, acc_q_reg;
    logic [RW-1:0]      rs_reg, acc_r_reg;

    // shared units
    logic                          cstart, cvec;
    logic [15:0]                   cang;
    logic signed [CW-1:0]          cx_out, cy_out;
    bnps_pkg::cordic_stat_t        cstat;
    logic signed [CW-1:0]          ma;
    logic signed [MW-1:0]          mb;
    logic signed [CW+MW-1:0]       prod;
    logic signed [CW-1:0]          psh;
    logic                          dstart, ddone;
    logic [TW-1:0]                 dquo;
    logic [RW-1:0]                 drem;

    logic                 q_accept;
    logic [TW-1:0]        lo_in, hi_in;
    logic [RNDW-1:0]      rounds_in;
    logic                 new_best;
    logic                 cub_last;
    logic signed [CW-1:0] fin;
    logic [RW:0]          r_sum;
    logic [TW-1:0]        acc_q_next;
    logic [RW-1:0]        acc_r_next;

    bnps_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cstart),
        .vec   (cvec),
        .ang   (cang),
        .a     (dx_reg),
        .b     (dy_reg),
        .x_out (cx_out),
        .y_out (cy_out),
        .stat  (cstat)
    );

    bnps_mul u_mul (
        .clk   (clk),
        .a     (ma),
        .b     (mb),
        .p_reg (prod)
    );

    bnps_div #(.DIVISOR(SAMPLES)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .num   (hi_reg - lo_reg),
        .quo   (dquo),
        .rem   (drem),
        .done  (ddone)
    );

    assign q_accept     = query.valid && query.ready;
    assign query.ready  = (state_reg == S_IDLE);
    assign result.valid = (state_reg == S_OUT);
    assign result.data.result_low  = lo_reg;
    assign result.data.result_high = hi_reg;
    assign cfg.ready    = 1'b1;

    // product >> 16, floor
    assign psh = prod[CW+15:16];

    // clamp the incoming interval and round count
    always_comb
    begin
        lo_in = (query.data.search_low > bnps_pkg::ONE_Q16) ?
                bnps_pkg::ONE_Q16 : query.data.search_low;
        hi_in = (query.data.search_high > bnps_pkg::ONE_Q16) ?
                bnps_pkg::ONE_Q16 : query.data.search_high;
        if (hi_in < lo_in)
            hi_in = lo_in;
        if (int'(query.data.rounds) > MAX_ROUNDS)
            rounds_in = RNDW'(MAX_ROUNDS);
        else
            rounds_in = RNDW'(query.data.rounds);
    end

    // CORDIC and divider launches
    always_comb
    begin
        cstart = 1'b0;
        cvec   = 1'b0;
        cang   = sh_reg;
        dstart = 1'b0;
        case (state_reg)
            S_SC_GO:
            begin
                cstart = 1'b1;
            end
            S_EC_GO:
            begin
                cstart = 1'b1;
                cang   = eh_reg;
            end
            S_CH_GO, S_DIST_GO:
            begin
                cstart = 1'b1;
                cvec   = 1'b1;
            end
            S_ROUND:
            begin
                dstart = (rounds_left_reg != '0);
            end
            default:
            begin
                cstart = 1'b0;
            end
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_MUL_LEN:
            begin
                ma = cx_out;
                mb = bnps_pkg::INV_GAIN;
            end
            S_MUL_D:
            begin
                ma = psh;
                mb = $signed({2'b00, gain_reg});
            end
            S_CTL0:
            begin
                ma = psh;
                mb = cs_reg;
            end
            S_CTL1:
            begin
                ma = d_reg;
                mb = ss_reg;
            end
            S_CTL2:
            begin
                ma = d_reg;
                mb = ce_reg;
            end
            S_CTL3:
            begin
                ma = d_reg;
                mb = se_reg;
            end
            S_CUB_MUL:
            begin
                ma = diff_reg;
                mb = $signed({1'b0, t_reg});
            end
            default:
            begin
                ma = '0;
            end
        endcase
    end

    // sample bookkeeping: t_k = lo + floor(k*span/SAMPLES) as q/r accumulators
    always_comb
    begin
        new_best = (k_reg == '0) || (cx_out < best_reg);
        cub_last = (op_reg == OPW'(bnps_pkg::CUB_OPS - 1));
        fin      = q0_reg + psh;
        r_sum    = {1'b0, acc_r_reg} + {1'b0, rs_reg};
        if (r_sum >= (RW+1)'(SAMPLES))
        begin
            acc_r_next = RW'(r_sum - (RW+1)'(SAMPLES));
            acc_q_next = acc_q_reg + qs_reg + 1'b1;
        end
        else
        begin
            acc_r_next = r_sum[RW-1:0];
            acc_q_next = acc_q_reg + qs_reg;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            gain_reg        <= bnps_pkg::GAIN_RESET;
            rounds_left_reg <= '0;
            k_reg           <= '0;
            op_reg          <= '0;
            axis_reg        <= 1'b0;
            pend_reg        <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                gain_reg <= cfg.data;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_accept)
                    begin
                        rounds_left_reg <= rounds_in;
                        state_reg       <= S_SC_GO;
                    end
                end
                S_SC_GO:   state_reg <= S_SC_W;
                S_SC_W:    if (cstat.done) state_reg <= S_EC_GO;
                S_EC_GO:   state_reg <= S_EC_W;
                S_EC_W:    if (cstat.done) state_reg <= S_CH_GO;
                S_CH_GO:   state_reg <= S_CH_W;
                S_CH_W:    if (cstat.done) state_reg <= S_MUL_LEN;
                S_MUL_LEN: state_reg <= S_MUL_D;
                S_MUL_D:   state_reg <= S_CTL0;
                S_CTL0:    state_reg <= S_CTL1;
                S_CTL1:    state_reg <= S_CTL2;
                S_CTL2:    state_reg <= S_CTL3;
                S_CTL3:    state_reg <= S_CTL4;
                S_CTL4:    state_reg <= S_ROUND;
                S_ROUND:
                begin
                    if (rounds_left_reg == '0)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_DIV_W;
                end
                S_DIV_W:
                begin
                    if (ddone)
                    begin
                        k_reg     <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= S_SAMP;
                    end
                end
                S_SAMP:
                begin
                    op_reg    <= '0;
                    axis_reg  <= 1'b0;
                    state_reg <= S_CUB_SEL;
                end
                S_CUB_SEL:
                begin
                    if (bnps_pkg::CUB_LERP[op_reg])
                        state_reg <= S_CUB_MUL;
                    else
                        op_reg <= op_reg + 1'b1;
                end
                S_CUB_MUL: state_reg <= S_CUB_ADD;
                S_CUB_ADD:
                begin
                    if (cub_last)
                    begin
                        op_reg <= '0;
                        if (!axis_reg)
                        begin
                            axis_reg  <= 1'b1;
                            state_reg <= S_CUB_SEL;
                        end
                        else
                        begin
                            state_reg <= S_DIST;
                        end
                    end
                    else
                    begin
                        op_reg    <= op_reg + 1'b1;
                        state_reg <= S_CUB_SEL;
                    end
                end
                S_DIST:    state_reg <= S_DIST_GO;
                S_DIST_GO: state_reg <= S_DIST_W;
                S_DIST_W:
                begin
                    if (cstat.done)
                    begin
                        // a new best waits for the next sample as its upper bound
                        if (new_best)
                            pend_reg <= (k_reg != KW'(SAMPLES));
                        else
                            pend_reg <= 1'b0;
                        if (k_reg == KW'(SAMPLES))
                        begin
                            state_reg <= S_NARROW;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_SAMP;
                        end
                    end
                end
                S_NARROW:
                begin
                    rounds_left_reg <= rounds_left_reg - 1'b1;
                    state_reg       <= S_ROUND;
                end
                S_OUT:
                begin
                    if (result.ready)
                        state_reg <= S_IDLE;
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (q_accept)
                begin
                    sx_reg <= query.data.start_x;
                    sy_reg <= query.data.start_y;
                    sh_reg <= query.data.start_heading;
                    ex_reg <= query.data.end_x;
                    ey_reg <= query.data.end_y;
                    eh_reg <= query.data.end_heading;
                    tx_reg <= query.data.target_x;
                    ty_reg <= query.data.target_y;
                    lo_reg <= lo_in;
                    hi_reg <= hi_in;
                end
            end
            S_SC_GO:
            begin
                dx_reg <= CW'(ex_reg) - CW'(sx_reg);
                dy_reg <= CW'(ey_reg) - CW'(sy_reg);
            end
            S_SC_W:
            begin
                if (cstat.done)
                begin
                    cs_reg <= cx_out[MW-1:0];
                    ss_reg <= cy_out[MW-1:0];
                end
            end
            S_EC_W:
            begin
                if (cstat.done)
                begin
                    ce_reg <= cx_out[MW-1:0];
                    se_reg <= cy_out[MW-1:0];
                end
            end
            S_CTL0: d_reg   <= psh;
            S_CTL1: px1_reg <= CW'(sx_reg) + psh;
            S_CTL2: py1_reg <= CW'(sy_reg) + psh;
            S_CTL3: px2_reg <= CW'(ex_reg) - psh;
            S_CTL4: py2_reg <= CW'(ey_reg) - psh;
            S_DIV_W:
            begin
                if (ddone)
                begin
                    qs_reg    <= dquo;
                    rs_reg    <= drem;
                    acc_q_reg <= '0;
                    acc_r_reg <= '0;
                end
            end
            S_SAMP:
            begin
                t_reg  <= lo_reg + acc_q_reg;
                q0_reg <= CW'(sx_reg);
                q1_reg <= px1_reg;
                q2_reg <= px2_reg;
                q3_reg <= CW'(ex_reg);
            end
            S_CUB_SEL:
            begin
                if (bnps_pkg::CUB_LERP[op_reg])
                begin
                    diff_reg <= q1_reg - q0_reg;
                end
                else
                begin
                    q0_reg <= q1_reg;
                    q1_reg <= q2_reg;
                    q2_reg <= q3_reg;
                end
            end
            S_CUB_ADD:
            begin
                if (cub_last && !axis_reg)
                begin
                    cx_reg <= fin;
                    q0_reg <= CW'(sy_reg);
                    q1_reg <= py1_reg;
                    q2_reg <= py2_reg;
                    q3_reg <= CW'(ey_reg);
                end
                else
                begin
                    if (cub_last)
                        cy_reg <= fin;
                    q0_reg <= q1_reg;
                    q1_reg <= q2_reg;
                    q2_reg <= q3_reg;
                    q3_reg <= fin;
                end
            end
            S_DIST:
            begin
                dx_reg <= cx_reg - CW'(tx_reg);
                dy_reg <= cy_reg - CW'(ty_reg);
            end
            S_DIST_W:
            begin
                if (cstat.done)
                begin
                    if (new_best)
                    begin
                        best_reg <= cx_out;
                        nlo_reg  <= (k_reg == '0) ? t_reg : tprev_reg;
                        if (k_reg == KW'(SAMPLES))
                            nhi_reg <= t_reg;
                    end
                    else if (pend_reg)
                    begin
                        nhi_reg <= t_reg;
                    end
                    tprev_reg <= t_reg;
                    acc_q_reg <= acc_q_next;
                    acc_r_reg <= acc_r_next;
                end
            end
            S_NARROW:
            begin
                lo_reg <= nlo_reg;
                hi_reg <= nhi_reg;
            end
            default:
            begin
                d_reg <= d_reg;
            end
        endcase
    end

    a_interval_order: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.data.result_low <= result.data.result_high))
        else $error("result interval inverted");

    a_interval_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.data.result_high <= bnps_pkg::ONE_Q16))
        else $error("result bound above 1.0");

    a_cordic_free: assert property (@(posedge clk) disable iff (!rst_n)
        cstart |-> !cstat.busy)
        else $error("CORDIC launched while busy");

    a_bound_resolved: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NARROW) |-> !pend_reg)
        else $error("upper bound unresolved at narrowing");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(query.ready && result.valid))
        else $error("query taken while result pending");

endmodule

`default_nettype wire

// ===== rtl/bnps_mul.sv =====
`default_nettype none

// shared signed multiplier, product registered
module bnps_mul (
    input  wire logic                                          clk,
    input  wire logic signed [bnps_pkg::CW-1:0]                a,
    input  wire logic signed [bnps_pkg::MW-1:0]                b,
    output logic signed [bnps_pkg::CW+bnps_pkg::MW-1:0]        p_reg
);

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

endmodule

`default_nettype wire

// ===== rtl/bnps_div.sv =====
`default_nettype none

// divider by a constant: reciprocal multiply for the quotient, back-multiply
// and subtract for the remainder; start feeds mul_go, quo_go, rem_go, done
module bnps_div #(
    parameter int DIVISOR = 15
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [bnps_pkg::TW-1:0]       num,
    output logic [bnps_pkg::TW-1:0]            quo,
    output logic [$clog2(DIVISOR)-1:0]         rem,
    output logic                               done
);

    localparam int RW  = $clog2(DIVISOR);
    localparam int SH  = bnps_pkg::TW + RW;
    localparam int MCW = bnps_pkg::TW + 1;
    localparam int PW  = bnps_pkg::TW + MCW;
    // ceil(2^SH / DIVISOR): floor quotient is exact for every TW-bit numerator
    localparam logic [MCW-1:0] RECIP =
        MCW'(((longint'(1) << SH) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR));

    logic [bnps_pkg::TW-1:0] n_reg;
    logic [PW-1:0]           p_reg;
    logic [bnps_pkg::TW-1:0] q_reg;
    logic [RW-1:0]           r_reg;
    logic                    mul_go_reg;
    logic                    quo_go_reg;
    logic                    rem_go_reg;
    logic                    done_reg;

    logic [bnps_pkg::TW-1:0] qd;
    logic [bnps_pkg::TW-1:0] r_full;

    always_comb
    begin
        qd     = q_reg * bnps_pkg::TW'(DIVISOR);
        r_full = n_reg - qd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_go_reg <= 1'b0;
            quo_go_reg <= 1'b0;
            rem_go_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            mul_go_reg <= start;
            quo_go_reg <= mul_go_reg;
            rem_go_reg <= quo_go_reg;
            done_reg   <= rem_go_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            n_reg <= num;
        if (mul_go_reg)
            p_reg <= PW'(n_reg) * PW'(RECIP);
        if (quo_go_reg)
            q_reg <= bnps_pkg::TW'(p_reg >> SH);
        if (rem_go_reg)
            r_reg <= r_full[RW-1:0];
    end

    assign quo  = q_reg;
    assign rem  = r_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/bnps_cordic.sv =====
`default_nettype none

// shared CORDIC, one micro-rotation per cycle
// rotation: sin/cos of a binary angle (Q0.16), vectoring: raw magnitude of (|a|,|b|)
module bnps_cordic (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic                              vec,
    input  wire logic [15:0]                       ang,
    input  wire logic signed [bnps_pkg::CW-1:0]    a,
    input  wire logic signed [bnps_pkg::CW-1:0]    b,
    output logic signed [bnps_pkg::CW-1:0]         x_out,
    output logic signed [bnps_pkg::CW-1:0]         y_out,
    output bnps_pkg::cordic_stat_t                 stat
);

    localparam int IW = $clog2(bnps_pkg::CSTEPS);

    logic signed [bnps_pkg::CW-1:0] x_reg;
    logic signed [bnps_pkg::CW-1:0] y_reg;
    logic signed [bnps_pkg::ZW-1:0] z_reg;
    logic                           vec_reg;
    logic                           neg_reg;
    logic [IW-1:0]                  i_reg;
    logic                           run_reg;
    logic                           done_reg;

    logic [23:0]                    z_red;
    logic                           neg_load;
    logic                           sigma;
    logic signed [bnps_pkg::CW-1:0] x_sh;
    logic signed [bnps_pkg::CW-1:0] y_sh;

    // fold quadrants 1 and 2 by a half turn, negate the result later
    always_comb
    begin
        z_red    = {ang, 8'h00};
        neg_load = 1'b0;
        if (ang[15] ^ ang[14])
        begin
            z_red    = z_red - 24'h800000;
            neg_load = 1'b1;
        end
    end

    always_comb
    begin
        sigma = vec_reg ? y_reg[bnps_pkg::CW-1] : !z_reg[bnps_pkg::ZW-1];
        x_sh  = x_reg >>> i_reg;
        y_sh  = y_reg >>> i_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                i_reg   <= '0;
            end
            else if (run_reg)
            begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == IW'(bnps_pkg::CSTEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            vec_reg <= vec;
            if (vec)
            begin
                x_reg   <= a[bnps_pkg::CW-1] ? -a : a;
                y_reg   <= b[bnps_pkg::CW-1] ? -b : b;
                z_reg   <= '0;
                neg_reg <= 1'b0;
            end
            else
            begin
                x_reg   <= bnps_pkg::CW'(bnps_pkg::INV_GAIN);
                y_reg   <= '0;
                z_reg   <= {{(bnps_pkg::ZW-24){z_red[23]}}, z_red};
                neg_reg <= neg_load;
            end
        end
        else if (run_reg)
        begin
            if (sigma)
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - bnps_pkg::atan_step(4'(i_reg));
            end
            else
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + bnps_pkg::atan_step(4'(i_reg));
            end
        end
    end

    assign x_out     = neg_reg ? -x_reg : x_reg;
    assign y_out     = neg_reg ? -y_reg : y_reg;
    assign stat.busy = run_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== tb/sv/bezier_nearest_param_search_test.sv =====
`default_nettype none

// Scoreboard: fixed-point model of the nearest-parameter search plus a queue
// of expected final intervals.
class interval_scoreboard;
    bnps_pkg::result_t pending_q[$];
    logic [15:0]       gain;
    int                mismatches;
    int                checked;

    function new();
        gain       = bnps_pkg::GAIN_RESET;
        mismatches = 0;
        checked    = 0;
    endfunction

    static function longint sra(longint v, int s);
        return v >>> s;
    endfunction

    static function void sin_cos(logic [15:0] ang, output longint c, output longint s);
        longint x, y, nx, zs;
        logic [23:0] z;
        logic [1:0] q;
        bit neg;
        longint atab[16];
        atab = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        z   = {ang, 8'd0};
        q   = z[23:22];
        neg = 0;
        x   = 39797;
        y   = 0;
        if (q == 2'd1 || q == 2'd2)
        begin
            z   = z - 24'h800000;
            neg = 1;
        end
        zs = z[23] ? longint'(z) - 64'sh1000000 : longint'(z);
        for (int i = 0; i < 16; i++)
        begin
            if (zs >= 0)
            begin
                nx = x - sra(y, i);
                y  = y + sra(x, i);
                zs -= atab[i];
            end
            else
            begin
                nx = x + sra(y, i);
                y  = y - sra(x, i);
                zs += atab[i];
            end
            x = nx;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    static function longint vec_mag(longint a, longint b);
        longint x, y, nx;
        x = a < 0 ? -a : a;
        y = b < 0 ? -b : b;
        for (int i = 0; i < 16; i++)
        begin
            if (y >= 0)
            begin
                nx = x + sra(y, i);
                y  = y - sra(x, i);
            end
            else
            begin
                nx = x - sra(y, i);
                y  = y + sra(x, i);
            end
            x = nx;
        end
        return x;
    endfunction

    static function longint mix(longint a, longint b, longint t);
        return a + sra((b - a) * t, 16);
    endfunction

    static function longint curve_at(longint p0, longint p1, longint p2, longint p3,
                                     longint t);
        longint a, b, c;
        a = mix(p0, p1, t);
        b = mix(p1, p2, t);
        c = mix(p2, p3, t);
        return mix(mix(a, b, t), mix(b, c, t), t);
    endfunction

    function bnps_pkg::result_t search_interval(bnps_pkg::query_t qy);
        localparam int NS = 15;
        localparam int MAXR = 8;
        longint sx, sy, ex, ey, tx, ty, lo, hi, cs, ss, ce, se, len, d;
        longint px[4], py[4];
        longint span, best, m, t, nlo, nhi;
        int rnds, bi;
        bnps_pkg::result_t res;
        sx = longint'(qy.start_x);  sy = longint'(qy.start_y);
        ex = longint'(qy.end_x);    ey = longint'(qy.end_y);
        tx = longint'(qy.target_x); ty = longint'(qy.target_y);
        lo = longint'(qy.search_low);
        hi = longint'(qy.search_high);
        rnds = int'(qy.rounds);
        if (lo > 65536) lo = 65536;
        if (hi > 65536) hi = 65536;
        if (hi < lo) hi = lo;
        if (rnds > MAXR) rnds = MAXR;
        sin_cos(qy.start_heading, cs, ss);
        sin_cos(qy.end_heading, ce, se);
        len = (vec_mag(ex - sx, ey - sy) * 39797) >>> 16;
        d   = (len * longint'(gain)) >>> 16;
        px[0] = sx; py[0] = sy;
        px[1] = sx + sra(d * cs, 16); py[1] = sy + sra(d * ss, 16);
        px[2] = ex - sra(d * ce, 16); py[2] = ey - sra(d * se, 16);
        px[3] = ex; py[3] = ey;
        for (int r = 0; r < rnds; r++)
        begin
            span = hi - lo;
            best = 0;
            bi   = 0;
            for (int k = 0; k <= NS; k++)
            begin
                t = lo + (k * span) / NS;
                m = vec_mag(curve_at(px[0], px[1], px[2], px[3], t) - tx,
                            curve_at(py[0], py[1], py[2], py[3], t) - ty);
                if (k == 0 || m < best)
                begin
                    best = m;
                    bi   = k;
                end
            end
            if (bi == 0)
            begin
                nlo = lo;
                nhi = lo + span / NS;
            end
            else if (bi == NS)
            begin
                nlo = lo + ((NS - 1) * span) / NS;
                nhi = hi;
            end
            else
            begin
                nlo = lo + ((bi - 1) * span) / NS;
                nhi = lo + ((bi + 1) * span) / NS;
            end
            lo = nlo;
            hi = nhi;
        end
        res.result_low  = lo[16:0];
        res.result_high = hi[16:0];
        return res;
    endfunction

    function void note_query(bnps_pkg::query_t qy);
        pending_q.push_back(search_interval(qy));
    endfunction

    function void check_result(bnps_pkg::result_t got);
        bnps_pkg::result_t want;
        checked++;
        if (pending_q.size() == 0)
        begin
            $display("%0t: unexpected result low=%0d high=%0d", $realtime,
                     got.result_low, got.result_high);
            mismatches++;
            return;
        end
        want = pending_q.pop_front();
        if (got.result_low !== want.result_low)
        begin
            $display("%0t: result_low expected %0d actual %0d", $realtime,
                     want.result_low, got.result_low);
            mismatches++;
        end
        if (got.result_high !== want.result_high)
        begin
            $display("%0t: result_high expected %0d actual %0d", $realtime,
                     want.result_high, got.result_high);
            mismatches++;
        end
    endfunction
endclass

module bezier_nearest_param_search_test;

    // the idle watchdog limit allows for the longest query at MAX_ROUNDS plus
    // the long receiver hold-off
    localparam int IDLE_LIMIT = 60000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bnps_query_if  query ();
    bnps_result_if result ();
    bnps_cfg_if    cfg ();

    bezier_nearest_param_search u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    always #1 clk = ~clk;

    interval_scoreboard sb;
    int  idle_cycles;
    int  queries_sent;
    // receiver hold-off request, counted in the receiver's own process
    int  hold_off_req;

    initial
    begin
        sb = new();
        query.valid  = 1'b0;
        query.data   = '0;
        result.ready = 1'b0;
        cfg.valid    = 1'b0;
        cfg.data     = '0;
        hold_off_req  = 0;
        idle_cycles   = 0;
        queries_sent  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // monitor: input transactions into the scoreboard, result transactions checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (query.valid && query.ready)
                sb.note_query(query.data);
            if (result.valid && result.ready)
                sb.check_result(result.data);
            if ((query.valid && query.ready) || (result.valid && result.ready) ||
                (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog, no transaction for %0d cycles", $realtime, idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stall pattern, plus long hold-offs on request
    initial
    begin
        int mode;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req > 0)
            begin
                result.ready <= 1'b0;
                repeat (hold_off_req) @(posedge clk);
                hold_off_req = 0;
            end
            mode = $urandom_range(0, 9);
            if (mode < 4)
                result.ready <= 1'b1;
            else if (mode < 7)
                result.ready <= 1'($urandom_range(0, 1));
            else
                result.ready <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clk);
        end
    end

    task automatic write_gain(logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        sb.gain = value;
    endtask

    // wait for every expected interval, then let the block settle
    task automatic drain();
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send_query(bnps_pkg::query_t qy);
        query.valid <= 1'b1;
        query.data  <= qy;
        @(posedge clk);
        while (!query.ready)
            @(posedge clk);
        query.valid <= 1'b0;
        queries_sent++;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return 32'sh80000000;
            1:       return 32'sh7fffffff;
            2:       return $urandom();
            default: return $signed($urandom_range(0, 2000000)) - 1000000;
        endcase
    endfunction

    function automatic bnps_pkg::query_t rand_query();
        bnps_pkg::query_t qy;
        int n;
        qy.start_x       = rand_coord();
        qy.start_y       = rand_coord();
        qy.end_x         = rand_coord();
        qy.end_y         = rand_coord();
        // target near the curve most of the time so the search narrows in
        if ($urandom_range(0, 3) != 0)
        begin
            qy.target_x = (qy.start_x >>> 1) + (qy.end_x >>> 1)
                          + $signed($urandom_range(0, 200000)) - 100000;
            qy.target_y = (qy.start_y >>> 1) + (qy.end_y >>> 1)
                          + $signed($urandom_range(0, 200000)) - 100000;
        end
        else
        begin
            qy.target_x = rand_coord();
            qy.target_y = rand_coord();
        end
        qy.start_heading = 16'($urandom());
        qy.end_heading   = 16'($urandom());
        n = $urandom_range(0, 9);
        if (n == 0)
        begin
            // bounds above 1.0, and high below low
            qy.search_low  = 17'($urandom_range(0, 131071));
            qy.search_high = 17'($urandom_range(0, 131071));
        end
        else
        begin
            qy.search_low  = 17'($urandom_range(0, 32768));
            qy.search_high = 17'($urandom_range(32'(qy.search_low), 65536));
        end
        // mostly few rounds to keep the run short; now and then the maximum or above it
        n = $urandom_range(0, 19);
        if (n == 0)
            qy.rounds = 4'($urandom_range(9, 15));
        else if (n < 3)
            qy.rounds = 4'd8;
        else
            qy.rounds = 4'($urandom_range(0, 3));
        return qy;
    endfunction

    task automatic directed_phase();
        bnps_pkg::query_t qy;
        // straight line along x, target at the start: first sample nearest
        qy = '{start_x: 0, start_y: 0, start_heading: 16'd0, end_x: 32'sh00100000,
               end_y: 0, end_heading: 16'd0, target_x: -32'sh00010000, target_y: 0,
               search_low: 17'd0, search_high: 17'd65536, rounds: 4'd3};
        send_query(qy);
        // target beyond the end: last sample nearest
        qy.target_x = 32'sh00200000;
        send_query(qy);
        // target mid-way: interior sample
        qy.target_x = 32'sh00080000;
        qy.target_y = 32'sh00010000;
        send_query(qy);
        // rounds zero, then above the maximum
        qy.rounds = 4'd0;
        send_query(qy);
        qy.rounds = 4'd15;
        send_query(qy);
        // high below low, bounds above 1.0
        qy.rounds      = 4'd2;
        qy.search_low  = 17'd40000;
        qy.search_high = 17'd1000;
        send_query(qy);
        qy.search_low  = 17'h1ffff;
        qy.search_high = 17'h1ffff;
        send_query(qy);
        qy.search_low  = 17'd65536;
        qy.search_high = 17'd70000;
        send_query(qy);
        // zero-width interval
        qy.search_low  = 17'd12345;
        qy.search_high = 17'd12345;
        send_query(qy);
        // coincident poses: every sample ties, the first wins
        qy = '{start_x: 32'sh00050000, start_y: -32'sh00030000, start_heading: 16'h4000,
               end_x: 32'sh00050000, end_y: -32'sh00030000, end_heading: 16'hc000,
               target_x: 0, target_y: 0, search_low: 0, search_high: 17'd65536,
               rounds: 4'd1};
        send_query(qy);
        // extreme coordinates and headings on and beside the quadrant boundaries
        qy = '{start_x: 32'sh80000000, start_y: 32'sh7fffffff, start_heading: 16'hffff,
               end_x: 32'sh7fffffff, end_y: 32'sh80000000, end_heading: 16'h8000,
               target_x: 32'sh7fffffff, target_y: 32'sh7fffffff,
               search_low: 0, search_high: 17'd65536, rounds: 4'd2};
        send_query(qy);
        qy.start_heading = 16'h4000;
        qy.end_heading   = 16'hc000;
        qy.target_x      = 32'sh80000000;
        qy.target_y      = 32'sh80000000;
        send_query(qy);
        qy.start_heading = 16'h3fff;
        qy.end_heading   = 16'h7fff;
        qy.rounds        = 4'd8;
        send_query(qy);
        qy.start_x = -1; qy.start_y = -1; qy.end_x = -1; qy.end_y = 1;
        qy.target_x = 1; qy.target_y = -1;
        qy.start_heading = 16'h0001; qy.end_heading = 16'hbfff;
        qy.rounds = 4'd1;
        send_query(qy);
    endtask

    task automatic random_phase(int count);
        int burst;
        while (count > 0)
        begin
            burst = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            for (int i = 0; i < burst && count > 0; i++)
            begin
                send_query(rand_query());
                count--;
            end
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [15:0] gains[4];
        @(posedge rst_n);
        @(posedge clk);

        // reset gain first
        directed_phase();
        drain();

        // extremes and a middle value of ctrl_gain, then random ones
        gains = '{16'd0, 16'hffff, 16'd32768, 16'd1};
        foreach (gains[g])
        begin
            write_gain(gains[g]);
            random_phase(30);
            if (g == 1)
            begin
                // long receiver hold-off while queries keep coming
                hold_off_req = 12000;
                random_phase(4);
            end
            // sender pauses until every expected interval is back
            drain();
        end
        for (int p = 0; p < 3; p++)
        begin
            write_gain(16'($urandom()));
            random_phase(50);
            drain();
        end
        write_gain(bnps_pkg::GAIN_RESET);
        random_phase(10);
        drain();

        $display("Covered %0d queries (%0d intervals checked) over 9 gain settings,",
                 queries_sent, sb.checked);
        $display("with directed edge cases, random stalls and a long output hold-off.");
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
